// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
// each macro expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// plain invariant checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

// ===== sv/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// types and constants shared by the typed message deframer
// ----------------------------------------------------------------------------
package tmd_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_EMPTY   = 3'd1,
      KIND_CURSOR  = 3'd2,
      KIND_KEY     = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_TYPE = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_PAY  = 5'b00100,
      PH_CUR  = 5'b01000,
      PH_KEY  = 5'b10000
   } phase_type;

   // message type bytes
   localparam logic [7:0] MSG_FRAME  = 8'd0;
   localparam logic [7:0] MSG_CURSOR = 8'd1;
   localparam logic [7:0] MSG_KEY    = 8'd2;

   // body lengths in bytes
   localparam logic [2:0] LEN_BYTES    = 3'd4;
   localparam logic [2:0] CURSOR_BYTES = 3'd4;
   localparam logic [2:0] KEY_BYTES    = 3'd3;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        frame_end;
      logic [31:0] frame_size;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      logic [15:0] key_code;
      logic [7:0]  key_action;
   } rsp_type;

endpackage

// ===== sv/tmd_skid.sv =====
// ----------------------------------------------------------------------------
// tmd_skid
// two-entry output buffer; ready toward the parser comes from a flop
// ----------------------------------------------------------------------------
module tmd_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tmd_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tmd_pkg::rsp_type rsp_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   tmd_pkg::rsp_type main_ff, main_in;
   tmd_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop        = main_valid_ff & rsp_ready;
   assign push_ready = ~skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // skid drains first; no push is taken while it is full
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push_valid;
         end
      end else if (push_valid) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sv/typed_message_deframer.sv =====
// ----------------------------------------------------------------------------
// typed_message_deframer
// splits a received byte stream into frames, cursor and key messages
// ----------------------------------------------------------------------------
// One received byte is taken per beat on the req_ channel, every cycle while
// req_ready is high, with no gaps needed between messages. A message opens
// with a type byte: 0 is a frame (4-byte little-endian length, then that
// many payload bytes, each sent out as its own beat with frame_end on the
// last; a zero length gives a single empty-frame beat on the last length
// byte), 1 is a cursor message (x then y, 16 bits each, little-endian) and
// 2 is a key message (16-bit code, 8-bit action); those two are sent as one
// beat on their final byte. Any other type byte yields an error beat
// carrying that byte, and the parser waits for the next type byte. Each byte
// gives zero or one result beat. Parser state is updated in the same cycle
// the byte is accepted, and the result lands in a registered two-entry
// output buffer that drives rsp_. req_ready comes from a flop and only drops
// while the buffer's spare entry holds a result that the consumer has not
// yet taken, so under no backpressure the block runs at one byte per clock.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module typed_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_end,
   output logic [31:0] rsp_frame_size,
   output logic [15:0] rsp_cursor_x,
   output logic [15:0] rsp_cursor_y,
   output logic [15:0] rsp_key_code,
   output logic [7:0]  rsp_key_action
);

   // parser state
   tmd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         header_count_ff, header_count_in;
   logic [31:0]        length_ff, length_in;
   logic [31:0]        remaining_ff, remaining_in;
   logic [31:0]        gather_ff, gather_in;

   logic               req_accept;
   logic [2:0]         count_inc;
   logic [31:0]        gather_put;
   logic [31:0]        remaining_dec;
   logic               res_valid;
   tmd_pkg::rsp_type   res;
   tmd_pkg::rsp_type   rsp_data;

   assign req_accept    = req_valid & req_ready;
   assign count_inc     = header_count_ff + 3'd1;
   assign remaining_dec = remaining_ff - 32'd1;

   // drop the new byte into its little-endian lane of the gather word
   always_comb begin
      gather_put = gather_ff;
      gather_put[{header_count_ff[1:0], 3'b000} +: 8] = req_rx_byte;
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      gather_in       = gather_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.kind        = tmd_pkg::KIND_PAYLOAD;
      res.payload_byte = req_rx_byte;
      if (req_accept) begin
         unique case (phase_ff)
            tmd_pkg::PH_LEN: begin
               // gather the 4-byte length
               header_count_in = count_inc;
               gather_in       = gather_put;
               if (count_inc >= tmd_pkg::LEN_BYTES) begin
                  length_in       = gather_put;
                  header_count_in = '0;
                  gather_in       = '0;
                  if (gather_put == 32'd0) begin
                     // empty frame reported on its last length byte
                     phase_in      = tmd_pkg::PH_TYPE;
                     res_valid     = 1'b1;
                     res.kind      = tmd_pkg::KIND_EMPTY;
                     res.frame_end = 1'b1;
                  end else begin
                     remaining_in = gather_put;
                     phase_in     = tmd_pkg::PH_PAY;
                  end
               end
            end
            tmd_pkg::PH_PAY: begin
               // pass payload bytes straight through
               remaining_in   = remaining_dec;
               res_valid      = 1'b1;
               res.kind       = tmd_pkg::KIND_PAYLOAD;
               res.frame_end  = (remaining_dec == 32'd0);
               res.frame_size = length_ff;
               if (remaining_dec == 32'd0) begin
                  phase_in = tmd_pkg::PH_TYPE;
               end
            end
            tmd_pkg::PH_CUR: begin
               header_count_in = count_inc;
               gather_in       = gather_put;
               if (count_inc >= tmd_pkg::CURSOR_BYTES) begin
                  res_valid       = 1'b1;
                  res.kind        = tmd_pkg::KIND_CURSOR;
                  res.cursor_x    = gather_put[15:0];
                  res.cursor_y    = gather_put[31:16];
                  header_count_in = '0;
                  gather_in       = '0;
                  phase_in        = tmd_pkg::PH_TYPE;
               end
            end
            tmd_pkg::PH_KEY: begin
               header_count_in = count_inc;
               gather_in       = gather_put;
               if (count_inc >= tmd_pkg::KEY_BYTES) begin
                  res_valid       = 1'b1;
                  res.kind        = tmd_pkg::KIND_KEY;
                  res.key_code    = gather_put[15:0];
                  res.key_action  = gather_put[23:16];
                  header_count_in = '0;
                  gather_in       = '0;
                  phase_in        = tmd_pkg::PH_TYPE;
               end
            end
            default: begin
               // awaiting a type byte
               header_count_in = '0;
               gather_in       = '0;
               if (req_rx_byte == tmd_pkg::MSG_FRAME) begin
                  phase_in = tmd_pkg::PH_LEN;
               end else if (req_rx_byte == tmd_pkg::MSG_CURSOR) begin
                  phase_in = tmd_pkg::PH_CUR;
               end else if (req_rx_byte == tmd_pkg::MSG_KEY) begin
                  phase_in = tmd_pkg::PH_KEY;
               end else begin
                  // unknown type: flag it and keep waiting
                  phase_in  = tmd_pkg::PH_TYPE;
                  res_valid = 1'b1;
                  res.kind  = tmd_pkg::KIND_ERROR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tmd_pkg::PH_TYPE;
         header_count_ff <= '0;
         length_ff       <= '0;
         remaining_ff    <= '0;
         gather_ff       <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         length_ff       <= length_in;
         remaining_ff    <= remaining_in;
         gather_ff       <= gather_in;
      end
   end

   // output buffer decouples rsp_ready from req_ready
   tmd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_kind     = rsp_data.kind;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_end    = rsp_data.frame_end;
   assign rsp_frame_size   = rsp_data.frame_size;
   assign rsp_cursor_x     = rsp_data.cursor_x;
   assign rsp_cursor_y     = rsp_data.cursor_y;
   assign rsp_key_code     = rsp_data.key_code;
   assign rsp_key_action   = rsp_data.key_action;

   // spare entry only fills while the output entry is held
   `ASSERT_IMPLY(a_stall_has_output, !req_ready, rsp_valid, "stall without a held result")
   // payload phase always has bytes left to pass
   `ASSERT_IMPLY(a_pay_not_empty, phase_ff == tmd_pkg::PH_PAY, remaining_ff != 32'd0,
      "payload phase with nothing remaining")
   // header byte counter never runs past a body
   `ASSERT_ALWAYS(a_count_range, header_count_ff < 3'd4, "header count out of range")
   // an empty frame result is always marked as a complete zero-length frame
   `ASSERT_IMPLY(a_empty_frame, rsp_valid && rsp_out_kind == tmd_pkg::KIND_EMPTY,
      rsp_frame_end && rsp_frame_size == 32'd0, "malformed empty frame result")

endmodule

// ===== test/tb_typed_message_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_typed_message_deframer
// self-checking bench for the typed message deframer
// ----------------------------------------------------------------------------
// Feeds a byte stream into the req_ channel: first a short table of directed
// beats (unknown type bytes, empty and short frames, cursor and key extremes),
// then random well-formed messages of every type with random content, and a
// few stray unknown type bytes. Each accepted byte runs through a local copy
// of the parser, and the result beat it should cause is queued. Every beat
// taken from rsp_ is compared against the oldest queued result. Both sides
// idle at random, with one calm window, and the consumer holds off once for a
// long stretch so that the output buffer fills and req_ready drops.
// ----------------------------------------------------------------------------
module tb_typed_message_deframer;

   localparam int N_RANDOM   = 1400;   // random bytes to send after the table
   localparam int STALL_MAX  = 1000;   // cycles with no beat before giving up
   localparam int HOLD_BEATS = 80;     // long consumer hold-off
   localparam int DRAIN      = 8;      // settle time after the last result

   // one stimulus row: the byte, and where obvious, the result it must give
   typedef struct packed {
      logic [7:0] rx;
      logic       known;      // result below is typed in by hand
      logic [2:0] kind;
      logic       fend;
   } stim_row_type;

   logic clock;
   logic reset;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_end;
   logic [31:0] rsp_frame_size;
   logic [15:0] rsp_cursor_x;
   logic [15:0] rsp_cursor_y;
   logic [15:0] rsp_key_code;
   logic [7:0]  rsp_key_action;

   typed_message_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_size   (rsp_frame_size),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_key_code     (rsp_key_code),
      .rsp_key_action   (rsp_key_action)
   );

   // directed table: unknown types, empty frame, short frame, cursor, key
   localparam int N_DIRECTED = 23;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{8'hFF, 1'b1, tmd_pkg::KIND_ERROR, 1'b0},   // highest unknown type
      '{8'h03, 1'b1, tmd_pkg::KIND_ERROR, 1'b0},   // lowest unknown type
      '{tmd_pkg::MSG_FRAME, 1'b0, 3'd0, 1'b0},     // empty frame: type, then zero length
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b1, tmd_pkg::KIND_EMPTY, 1'b1},   // done on the last length byte
      '{tmd_pkg::MSG_FRAME, 1'b0, 3'd0, 1'b0},     // two-byte frame, payload 00 ff
      '{8'h02, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'hFF, 1'b0, 3'd0, 1'b0},
      '{tmd_pkg::MSG_CURSOR, 1'b0, 3'd0, 1'b0},    // cursor x = ffff, y = 0
      '{8'hFF, 1'b0, 3'd0, 1'b0},
      '{8'hFF, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 1'b0, 3'd0, 1'b0},
      '{tmd_pkg::MSG_KEY, 1'b0, 3'd0, 1'b0},       // key code 1234, action ff
      '{8'h34, 1'b0, 3'd0, 1'b0},
      '{8'h12, 1'b0, 3'd0, 1'b0},
      '{8'hFF, 1'b0, 3'd0, 1'b0}
   };

   stim_row_type     byte_stream[$];        // everything the sender will offer
   tmd_pkg::rsp_type pending_msgs[$];       // result beats still owed by the block
   int               next_idx = 0;
   int               bytes_taken = 0;
   int               stall_cycles = 0;
   int               cycle_count = 0;
   int               mismatches = 0;
   bit               long_frame_sent = 1'b0;

   // parser state mirror
   tmd_pkg::phase_type ph_q = tmd_pkg::PH_TYPE;
   logic [2:0]         gather_cnt = '0;
   logic [31:0]        gather_q = '0;
   logic [31:0]        frame_len = '0;
   logic [31:0]        bytes_left = '0;

   // calm window: no idling on either side
   wire calm = (cycle_count >= 400) && (cycle_count < 900);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // gather one header or body byte, little-endian
   function automatic void gather_byte(input logic [7:0] b);
      gather_q[gather_cnt[1:0]*8 +: 8] = b;
      gather_cnt = gather_cnt + 3'd1;
   endfunction

   // advance the parser mirror by one received byte
   function automatic void deframe_byte(input logic [7:0] b, output bit emits,
                                        output tmd_pkg::rsp_type msg);
      msg = '0;
      msg.payload_byte = b;
      emits = 1'b0;
      case (ph_q)
         tmd_pkg::PH_LEN: begin
            gather_byte(b);
            if (gather_cnt >= tmd_pkg::LEN_BYTES) begin
               frame_len = gather_q;
               gather_cnt = '0;
               gather_q = '0;
               if (frame_len == 32'd0) begin
                  // empty frame completes right here
                  ph_q = tmd_pkg::PH_TYPE;
                  emits = 1'b1;
                  msg.kind = tmd_pkg::KIND_EMPTY;
                  msg.frame_end = 1'b1;
               end else begin
                  bytes_left = frame_len;
                  ph_q = tmd_pkg::PH_PAY;
               end
            end
         end
         tmd_pkg::PH_PAY: begin
            bytes_left = bytes_left - 32'd1;
            emits = 1'b1;
            msg.kind = tmd_pkg::KIND_PAYLOAD;
            msg.frame_end = (bytes_left == 32'd0);
            msg.frame_size = frame_len;
            if (bytes_left == 32'd0) ph_q = tmd_pkg::PH_TYPE;
         end
         tmd_pkg::PH_CUR: begin
            gather_byte(b);
            if (gather_cnt >= tmd_pkg::CURSOR_BYTES) begin
               emits = 1'b1;
               msg.kind = tmd_pkg::KIND_CURSOR;
               msg.cursor_x = gather_q[15:0];
               msg.cursor_y = gather_q[31:16];
               gather_cnt = '0;
               gather_q = '0;
               ph_q = tmd_pkg::PH_TYPE;
            end
         end
         tmd_pkg::PH_KEY: begin
            gather_byte(b);
            if (gather_cnt >= tmd_pkg::KEY_BYTES) begin
               emits = 1'b1;
               msg.kind = tmd_pkg::KIND_KEY;
               msg.key_code = gather_q[15:0];
               msg.key_action = gather_q[23:16];
               gather_cnt = '0;
               gather_q = '0;
               ph_q = tmd_pkg::PH_TYPE;
            end
         end
         default: begin
            // awaiting a type byte
            gather_cnt = '0;
            gather_q = '0;
            if (b == tmd_pkg::MSG_FRAME) begin
               ph_q = tmd_pkg::PH_LEN;
            end else if (b == tmd_pkg::MSG_CURSOR) begin
               ph_q = tmd_pkg::PH_CUR;
            end else if (b == tmd_pkg::MSG_KEY) begin
               ph_q = tmd_pkg::PH_KEY;
            end else begin
               ph_q = tmd_pkg::PH_TYPE;
               emits = 1'b1;
               msg.kind = tmd_pkg::KIND_ERROR;
            end
         end
      endcase
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      stim_row_type row;
      row = '{b, 1'b0, 3'd0, 1'b0};
      byte_stream = {byte_stream, row};
   endfunction

   // build the whole byte stream up front
   initial begin
      int          sel;
      int          roll;
      logic [31:0] len;
      foreach (DIRECTED[i]) byte_stream = {byte_stream, DIRECTED[i]};
      while (byte_stream.size() < N_DIRECTED + N_RANDOM) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            // frame: mostly short, some medium, one long
            roll = $urandom_range(0, 99);
            if (!long_frame_sent && byte_stream.size() > 600) begin
               len = 32'd300;
               long_frame_sent = 1'b1;
            end else if (roll < 15) begin
               len = 32'd0;
            end else if (roll < 90) begin
               len = $urandom_range(1, 8);
            end else begin
               len = $urandom_range(9, 64);
            end
            queue_byte(tmd_pkg::MSG_FRAME);
            for (int k = 0; k < 4; k++) queue_byte(len[k*8 +: 8]);
            for (int k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
         end else if (sel < 60) begin
            queue_byte(tmd_pkg::MSG_CURSOR);
            repeat (4) queue_byte(8'($urandom_range(0, 255)));
         end else if (sel < 80) begin
            queue_byte(tmd_pkg::MSG_KEY);
            repeat (3) queue_byte(8'($urandom_range(0, 255)));
         end else begin
            // stray unknown type byte
            queue_byte(8'($urandom_range(3, 255)));
         end
      end
   end

   // sender, prediction and result checking share one process so that a
   // result is always queued before it can be taken
   always @(posedge clock) begin
      bit               emits;
      bit               took;
      tmd_pkg::rsp_type want;
      tmd_pkg::rsp_type seen;
      stim_row_type     cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = 1'b0;
         if (req_valid && req_ready) begin
            took = 1'b1;
            cur = byte_stream[next_idx - 1];
            deframe_byte(cur.rx, emits, want);
            if (cur.known) begin
               // hand-typed result replaces the predicted one
               want = '0;
               want.kind = tmd_pkg::kind_type'(cur.kind);
               want.payload_byte = cur.rx;
               want.frame_end = cur.fend;
               emits = 1'b1;
            end
            if (emits) pending_msgs = {pending_msgs, want};
            bytes_taken <= bytes_taken + 1;
         end

         // offer the next beat, or hold the current one until taken
         if (!req_valid || took) begin
            if (next_idx < byte_stream.size() && (calm || $urandom_range(0, 99) >= 30)) begin
               req_valid <= 1'b1;
               req_rx_byte <= byte_stream[next_idx].rx;
               next_idx++;
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (rsp_valid && rsp_ready) begin
            took = 1'b1;
            seen.kind = tmd_pkg::kind_type'(rsp_out_kind);
            seen.payload_byte = rsp_payload_byte;
            seen.frame_end = rsp_frame_end;
            seen.frame_size = rsp_frame_size;
            seen.cursor_x = rsp_cursor_x;
            seen.cursor_y = rsp_cursor_y;
            seen.key_code = rsp_key_code;
            seen.key_action = rsp_key_action;
            if (pending_msgs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: kind %0d byte %h", seen.kind,
                           seen.payload_byte);
            end else begin
               want = pending_msgs.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch exp: kind %0d byte %h end %b size %h x %h y %h code %h act %h",
                              want.kind, want.payload_byte, want.frame_end, want.frame_size,
                              want.cursor_x, want.cursor_y, want.key_code, want.key_action);
                     $display("         got: kind %0d byte %h end %b size %h x %h y %h code %h act %h",
                              seen.kind, seen.payload_byte, seen.frame_end, seen.frame_size,
                              seen.cursor_x, seen.cursor_y, seen.key_code, seen.key_action);
                  end
               end
            end
         end

         stall_cycles = took ? 0 : stall_cycles + 1;
      end
   end

   // consumer: random stalls plus one long hold-off that backs up the input
   always @(posedge clock) begin
      int  hold_left;
      bit  hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_BEATS;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 30);
      end
   end

   // watchdog: too long with no beat on either channel
   initial begin
      while (stall_cycles < STALL_MAX) @(negedge clock);
      $display("status: fail");
      $finish;
   end

   // end of run: all bytes sent, all results seen, then a short settle
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      while (next_idx < byte_stream.size() || req_valid || pending_msgs.size() != 0)
         @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (mismatches == 0 && pending_msgs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/tmd_pkg.sv
sv/tmd_skid.sv
sv/typed_message_deframer.sv
test/tb_typed_message_deframer.sv
